// ===== sv/host_template_to_regex_assert.svh =====
// Assertion macros for the host template to regex block.
// Used by the top level; the macros expect aclk and aresetn in scope.
`ifndef HOST_TEMPLATE_TO_REGEX_ASSERT_SVH
`define HOST_TEMPLATE_TO_REGEX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("host_template_to_regex: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("host_template_to_regex: next-cycle check failed");

`endif

// ===== sv/htr_pkg.sv =====
// Shared types and constants for the host template to regex block.
// No dependencies; used by htr_encode and host_template_to_regex.
`default_nettype none

package htr_pkg;

    localparam int MAX_NESTING_DEF = 15;
    localparam int MAX_RESULTS     = 4;
    localparam int CNT_W           = 3;
    localparam int IDX_W           = 2;

    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        ST_SYMBOL         = 3'd0,
        ST_STRAY_CLOSE    = 3'd1,
        ST_MISPLACED_STAR = 3'd2,
        ST_UNCLOSED       = 3'd3,
        ST_TOO_DEEP       = 3'd4
    } status_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] syms;
        logic [CNT_W-1:0]            count;
        status_t                     final_status;
        logic                        template_end;
    } enc_result_t;

endpackage

`default_nettype wire

// ===== sv/htr_encode.sv =====
// Rewrites one template character into up to four regex results.
// Depends on htr_pkg for character codes, status codes and the result struct.
`default_nettype none

module htr_encode #(
    parameter int MAX_NESTING = htr_pkg::MAX_NESTING_DEF,
    parameter int DEPTH_W     = $clog2(MAX_NESTING + 1)
) (
    input  wire logic [7:0]         symbol_in,
    input  wire logic               is_first,
    input  wire logic               is_last,
    input  wire logic [DEPTH_W-1:0] depth_cur,
    input  wire logic               failed_cur,
    output htr_pkg::enc_result_t    result,
    output logic [DEPTH_W-1:0]      depth_next,
    output logic                    failed_next
);

    logic [DEPTH_W-1:0]             depth;
    logic                           fail;
    logic [htr_pkg::CNT_W-1:0]      n;
    htr_pkg::status_t               err;
    logic [htr_pkg::MAX_RESULTS-1:0][7:0] syms;

    always_comb begin
        depth = is_first ? '0 : depth_cur;
        fail  = is_first ? 1'b0 : failed_cur;
        n     = '0;
        err   = htr_pkg::ST_SYMBOL;
        syms  = '0;

        if (!fail) begin
            if (is_first && symbol_in != htr_pkg::CH_CARET) begin
                syms[n[htr_pkg::IDX_W-1:0]] = htr_pkg::CH_CARET;
                n = n + 1'b1;
            end
            case (symbol_in) inside
                htr_pkg::CH_LPAREN, htr_pkg::CH_LBRACK: begin
                    if (depth >= DEPTH_W'(MAX_NESTING)) begin
                        err = htr_pkg::ST_TOO_DEEP;
                    end else begin
                        depth = depth + 1'b1;
                        syms[n[htr_pkg::IDX_W-1:0]] = symbol_in;
                        n = n + 1'b1;
                    end
                end
                htr_pkg::CH_RPAREN, htr_pkg::CH_RBRACK: begin
                    if (depth == '0) begin
                        err = htr_pkg::ST_STRAY_CLOSE;
                    end else begin
                        depth = depth - 1'b1;
                        syms[n[htr_pkg::IDX_W-1:0]] = symbol_in;
                        n = n + 1'b1;
                    end
                end
                htr_pkg::CH_STAR: begin
                    if (depth != '0) begin
                        syms[n[htr_pkg::IDX_W-1:0]] = symbol_in;
                        n = n + 1'b1;
                    end else if (is_first || is_last) begin
                        syms[n[htr_pkg::IDX_W-1:0]] = htr_pkg::CH_DOT;
                        n = n + 1'b1;
                        syms[n[htr_pkg::IDX_W-1:0]] = htr_pkg::CH_STAR;
                        n = n + 1'b1;
                    end else begin
                        err = htr_pkg::ST_MISPLACED_STAR;
                    end
                end
                htr_pkg::CH_DOT: begin
                    if (depth == '0) begin
                        syms[n[htr_pkg::IDX_W-1:0]] = htr_pkg::CH_BSLASH;
                        n = n + 1'b1;
                    end
                    syms[n[htr_pkg::IDX_W-1:0]] = htr_pkg::CH_DOT;
                    n = n + 1'b1;
                end
                default: begin
                    syms[n[htr_pkg::IDX_W-1:0]] = symbol_in;
                    n = n + 1'b1;
                end
            endcase

            if (err == htr_pkg::ST_SYMBOL && is_last) begin
                if (depth != '0) begin
                    err = htr_pkg::ST_UNCLOSED;
                end else if (symbol_in != htr_pkg::CH_DOLLAR) begin
                    syms[n[htr_pkg::IDX_W-1:0]] = htr_pkg::CH_DOLLAR;
                    n = n + 1'b1;
                end
            end

            if (err != htr_pkg::ST_SYMBOL) begin
                syms[n[htr_pkg::IDX_W-1:0]] = 8'h00;
                n = n + 1'b1;
            end
        end
    end

    assign result.syms         = syms;
    assign result.count        = n;
    assign result.final_status = err;
    assign result.template_end = (err != htr_pkg::ST_SYMBOL) || is_last;
    assign depth_next          = fail ? depth_cur : depth;
    assign failed_next         = fail || (err != htr_pkg::ST_SYMBOL);

endmodule

`default_nettype wire

// ===== sv/host_template_to_regex.sv =====
// Host template to regex: results appear in the cycle after the input transaction,
// one result per cycle while m_ready is high, from a four-entry result buffer
// filled by htr_encode. A new input is taken while the buffer is empty or its
// final result leaves, so an item that yields no results never holds the input.
// Reset is synchronous, active low, and clears the depth, error flag and buffer count.
`default_nettype none
`include "host_template_to_regex_assert.svh"

module host_template_to_regex #(
    parameter int MAX_NESTING = htr_pkg::MAX_NESTING_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_symbol_in,
    input  wire logic       s_is_first,
    input  wire logic       s_is_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_symbol_out,
    output logic [2:0]      m_status,
    output logic            m_run_last,
    output logic            m_template_end
);

    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);

    logic [DEPTH_W-1:0]                   depth_reg, depth_next;
    logic                                 failed_reg, failed_next;
    logic [htr_pkg::MAX_RESULTS-1:0][7:0] sym_reg;
    htr_pkg::status_t                     stat_reg;
    logic                                 te_reg;
    logic [htr_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic [htr_pkg::IDX_W-1:0]            idx_reg, idx_next;
    htr_pkg::enc_result_t                 enc;
    logic                                 at_last, pop, pop_last, accept;

    htr_encode #(
        .MAX_NESTING(MAX_NESTING),
        .DEPTH_W    (DEPTH_W)
    ) u_encode (
        .symbol_in  (s_symbol_in),
        .is_first   (s_is_first),
        .is_last    (s_is_last),
        .depth_cur  (depth_reg),
        .failed_cur (failed_reg),
        .result     (enc),
        .depth_next (depth_next),
        .failed_next(failed_next)
    );

    assign m_valid  = (cnt_reg != '0);
    assign at_last  = ({1'b0, idx_reg} == (cnt_reg - 1'b1));
    assign pop      = m_valid && m_ready;
    assign pop_last = pop && at_last;
    assign s_ready  = !m_valid || pop_last;
    assign accept   = s_valid && s_ready;

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (accept) begin
            cnt_next = enc.count;
            idx_next = '0;
        end else if (pop_last) begin
            cnt_next = '0;
        end else if (pop) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            idx_reg    <= '0;
            depth_reg  <= '0;
            failed_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (accept) begin
                depth_reg  <= depth_next;
                failed_reg <= failed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sym_reg  <= enc.syms;
            stat_reg <= enc.final_status;
            te_reg   <= enc.template_end;
        end
    end

    assign m_symbol_out   = sym_reg[idx_reg];
    assign m_status       = at_last ? 3'(stat_reg) : 3'(htr_pkg::ST_SYMBOL);
    assign m_run_last     = at_last;
    assign m_template_end = at_last && te_reg;

    `HTR_ASSERT_SAME(a_error_closes, m_valid && m_status != 3'(htr_pkg::ST_SYMBOL), m_run_last && m_template_end && m_symbol_out == 8'h00)
    `HTR_ASSERT_NEXT(a_swallow_silent, accept && failed_reg && !s_is_first, !m_valid)
    `HTR_ASSERT_SAME(a_depth_bound, 1'b1, depth_reg <= DEPTH_W'(MAX_NESTING))

endmodule

`default_nettype wire
